FILE: src/lje_pkg.sv
// Shared types, register indexes and fixed-point helpers for the Lennard-Jones
// energy sum block. No dependencies; every other file imports this package.
package lje_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	// Covers 64 + 2*F + 30 iterations for F up to 80.
	localparam int DIV_CNT_W = 8;

	localparam logic REG_DIPOLE_ENABLE = 1'b0;
	localparam logic REG_POLARIZABILITY = 1'b1;

	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic signed [32:0] d_x;
		logic signed [32:0] d_y;
		logic signed [32:0] d_z;
		logic [15:0] eps;
		logic [15:0] sig;
		logic signed [15:0] q;
		logic last;
		logic coincident;
	} lje_item_t;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] b;
	} lje_mul_req_t;

	typedef struct packed {
		logic done;
		logic [127:0] prod;
	} lje_mul_rsp_t;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] b;
		logic [DIV_CNT_W-1:0] k;
	} lje_div_req_t;

	typedef struct packed {
		logic done;
		logic sat;
		logic [63:0] quo;
	} lje_div_rsp_t;

	// Shift a full product right and saturate to all ones; bit 64 is the flag.
	function automatic logic [64:0] mulq_fin(input logic [127:0] p, input int unsigned sh);
		logic [127:0] s;
		s = p >> sh;
		if (|s[127:64])
			return {1'b1, {64{1'b1}}};
		return {1'b0, s[63:0]};
	endfunction

	function automatic logic [64:0] signed_term(input logic [63:0] mag, input logic neg);
		logic [63:0] m;
		logic s;
		s = mag[63];
		m = s ? INT64_MAX : mag;
		return {s, neg ? 64'(-m) : m};
	endfunction

	function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return {1'b1, s[64] ? INT64_MIN : INT64_MAX};
		return {1'b0, s[63:0]};
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? 64'(-v) : v;
	endfunction

	function automatic logic [31:0] abs_d(input logic signed [32:0] v);
		logic [32:0] m;
		m = v[32] ? 33'(-v) : v;
		return m[31:0];
	endfunction

endpackage

FILE: src/lj_induced_dipole_energy_sum.sv
// Lennard-Jones 12-6 energy sum with ion-induced dipole term, one atom word at a time.
// Atoms are worked one at a time; the sequencer takes a shorter path with zero well depth,
// a zero offset or a saturating quotient, and a coincident atom skips the energy terms.
// A last atom adds the output step, and with the dipole term on also the field energy.
// Each word passes the input register and the queue before it reaches the sequencer.
// Reset clears the accumulators, the error flag, the queue and both configuration registers.
module lj_induced_dipole_energy_sum #(
	parameter int COORD_FRAC_BITS = lje_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] probe_x,
	input  logic signed [31:0] probe_y,
	input  logic signed [31:0] probe_z,
	input  logic signed [31:0] atom_x,
	input  logic signed [31:0] atom_y,
	input  logic signed [31:0] atom_z,
	input  logic [15:0] atom_well_depth,
	input  logic [15:0] atom_radius,
	input  logic signed [15:0] atom_charge,
	input  logic last_atom,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [63:0] total_energy,
	output logic overlap_or_saturated,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [31:0] cfg_data
);
	import lje_pkg::*;

	logic dipole_enable_q;
	logic [31:0] polarizability_q;
	logic push;
	logic push_ready;
	lje_item_t push_item;
	logic pop;
	logic head_valid;
	lje_item_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dipole_enable_q <= 1'b0;
			polarizability_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIPOLE_ENABLE: dipole_enable_q <= cfg_data[0];
				REG_POLARIZABILITY: polarizability_q <= cfg_data;
				default: dipole_enable_q <= dipole_enable_q;
			endcase
		end
	end

	lje_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.probe_x(probe_x), .probe_y(probe_y), .probe_z(probe_z),
		.atom_x(atom_x), .atom_y(atom_y), .atom_z(atom_z),
		.atom_well_depth(atom_well_depth), .atom_radius(atom_radius),
		.atom_charge(atom_charge), .last_atom(last_atom),
		.push(push), .item(push_item), .push_ready(push_ready)
	);

	lje_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.push_ready(push_ready), .pop(pop), .head_valid(head_valid), .head(head)
	);

	lje_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head), .pop(pop),
		.dipole_enable(dipole_enable_q), .probe_polarizability(polarizability_q),
		.out_valid(out_valid), .out_ready(out_ready), .total_energy(total_energy),
		.overlap_or_saturated(overlap_or_saturated)
	);

endmodule

FILE: src/lje_front.sv
// Input stage: takes a word, forms the probe-to-atom offsets and flags a coincident atom.
// Depends on lje_pkg.
module lje_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] probe_x,
	input  logic signed [31:0] probe_y,
	input  logic signed [31:0] probe_z,
	input  logic signed [31:0] atom_x,
	input  logic signed [31:0] atom_y,
	input  logic signed [31:0] atom_z,
	input  logic [15:0] atom_well_depth,
	input  logic [15:0] atom_radius,
	input  logic signed [15:0] atom_charge,
	input  logic last_atom,
	output logic push,
	output lje_pkg::lje_item_t item,
	input  logic push_ready
);
	import lje_pkg::*;

	logic v_s1;
	lje_item_t item_s1;
	lje_item_t next_item;

	always_comb begin
		next_item.d_x = 33'(probe_x) - 33'(atom_x);
		next_item.d_y = 33'(probe_y) - 33'(atom_y);
		next_item.d_z = 33'(probe_z) - 33'(atom_z);
		next_item.eps = atom_well_depth;
		next_item.sig = atom_radius;
		next_item.q = atom_charge;
		next_item.last = last_atom;
		next_item.coincident = (probe_x == atom_x) && (probe_y == atom_y) && (probe_z == atom_z);
	end

	assign in_ready = !v_s1 || push_ready;
	assign push = v_s1 && push_ready;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= next_item;
		end
	end

endmodule

FILE: src/lje_queue.sv
// Two-entry queue of classified words between the front and back parts.
// Depends on lje_pkg.
module lje_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lje_pkg::lje_item_t push_item,
	output logic push_ready,
	input  logic pop,
	output logic head_valid,
	output lje_pkg::lje_item_t head
);
	import lje_pkg::*;

	lje_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: src/lje_mul.sv
// Shared 64 by 64 multiplier built from one 32 by 32 multiplier over four partial products.
// Depends on lje_pkg.
module lje_mul (
	input  logic clk,
	input  logic arst_n,
	input  lje_pkg::lje_mul_req_t req,
	output lje_pkg::lje_mul_rsp_t rsp
);
	import lje_pkg::*;

	logic busy_q;
	logic done_q;
	logic [2:0] cnt_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [127:0] prod_q;
	logic [63:0] pp_s1;
	logic [6:0] shift_s1;
	logic [31:0] a_part;
	logic [31:0] b_part;

	assign a_part = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[1] ? b_q[63:32] : b_q[31:0];
	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial product is registered and added into the sum in the next cycle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			prod_q <= '0;
		end else if (busy_q) begin
			pp_s1 <= 64'(a_part) * 64'(b_part);
			shift_s1 <= {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0], 5'd0};
			if (cnt_q != 3'd0)
				prod_q <= prod_q + (128'(pp_s1) << shift_s1);
		end
	end

endmodule

FILE: src/lje_div.sv
// Bit-serial restoring divider giving floor(a * 2^k / b), saturating to all ones.
// Depends on lje_pkg.
module lje_div (
	input  logic clk,
	input  logic arst_n,
	input  lje_pkg::lje_div_req_t req,
	output lje_pkg::lje_div_rsp_t rsp
);
	import lje_pkg::*;

	logic busy_q;
	logic done_q;
	logic sat_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [64:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, num_q[63]};
	assign ge = rem_sh >= {1'b0, den_q};
	assign rsp.done = done_q;
	assign rsp.sat = sat_q;
	assign rsp.quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.a == 64'd0 || req.b == 64'd0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (quo_q[63] || cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Numerator bits come out of the top of num_q; zeros follow for the 2^k scaling.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.a;
			den_q <= req.b;
			rem_q <= '0;
			cnt_q <= DIV_CNT_W'(64) + req.k;
			if (req.a == 64'd0) begin
				quo_q <= '0;
				sat_q <= 1'b0;
			end else if (req.b == 64'd0) begin
				quo_q <= '1;
				sat_q <= 1'b1;
			end else begin
				quo_q <= '0;
				sat_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (quo_q[63]) begin
				quo_q <= '1;
				sat_q <= 1'b1;
			end else begin
				rem_q <= ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
				quo_q <= {quo_q[62:0], ge};
				num_q <= {num_q[62:0], 1'b0};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/lje_back.sv
// Sequencer that works one atom at a time: distance, LJ term, field terms and the final sum.
// Depends on lje_pkg, lje_mul and lje_div.
module lje_back #(
	parameter int COORD_FRAC_BITS = lje_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  lje_pkg::lje_item_t head,
	output logic pop,
	input  logic dipole_enable,
	input  logic [31:0] probe_polarizability,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [63:0] total_energy,
	output logic overlap_or_saturated
);
	import lje_pkg::*;

	localparam logic [DIV_CNT_W-1:0] K_S = DIV_CNT_W'(2 * COORD_FRAC_BITS + 6);
	localparam logic [DIV_CNT_W-1:0] K_INV = DIV_CNT_W'(2 * COORD_FRAC_BITS + 30);
	localparam logic [DIV_CNT_W-1:0] K_C = DIV_CNT_W'(31);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_WAIT, ST_LJ_DIV, ST_LJ_M1, ST_LJ_M2, ST_LJ_M3, ST_LJ_M4,
		ST_LJ_ADD, ST_DIP, ST_INV_WAIT, ST_SQRT, ST_C_WAIT, ST_F_M1, ST_F_M2,
		ST_FIN, ST_E2_WAIT, ST_ALPHA_WAIT, ST_OUT
	} state_t;

	state_t state_q;
	lje_item_t it_q;
	lje_mul_req_t mreq_q;
	lje_mul_rsp_t mrsp;
	lje_div_req_t dreq_q;
	lje_div_rsp_t drsp;

	logic [1:0] axis_q;
	logic [63:0] r2q_q;
	logic [63:0] s_q;
	logic [63:0] s3_q;
	logic [63:0] term_q;
	logic [63:0] inv2_q;
	logic [31:0] rr_q;
	logic [34:0] sq_rem_q;
	logic [63:0] sq_v_q;
	logic [4:0] sq_cnt_q;
	logic neg_q;
	logic ls_q;
	logic sat_q;
	logic err_q;
	logic fs_q;
	logic [63:0] e2_q;
	logic [63:0] total_q;
	logic [63:0] lj_q;
	logic [63:0] facc_q [3];
	logic out_valid_q;
	logic [63:0] out_total_q;
	logic out_flag_q;

	logic signed [32:0] d_cur;
	logic signed [32:0] d_next;
	logic [63:0] r2q_new;
	logic [64:0] f32;
	logic [64:0] f12;
	logic [64:0] f10;
	logic [64:0] f17;
	logic [63:0] diff;
	logic [64:0] lj_st;
	logic [64:0] lj_sum;
	logic [64:0] fd_st;
	logic [64:0] fd_sum;
	logic [64:0] e2_sum;
	logic [64:0] al_st;
	logic [64:0] al_sum;
	logic [34:0] sq_sh;
	logic [34:0] sq_trial;
	logic sq_ge;
	logic [31:0] root_new;
	logic [15:0] abs_q;

	lje_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq_q), .rsp(mrsp));
	lje_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq_q), .rsp(drsp));

	always_comb begin
		case (axis_q)
			2'd0: begin
				d_cur = it_q.d_x;
				d_next = it_q.d_y;
			end
			2'd1: begin
				d_cur = it_q.d_y;
				d_next = it_q.d_z;
			end
			default: begin
				d_cur = it_q.d_z;
				d_next = it_q.d_z;
			end
		endcase
	end

	always_comb begin
		r2q_new = r2q_q + {2'b00, mrsp.prod[63:2]};
		f32 = mulq_fin(mrsp.prod, 32);
		f12 = mulq_fin(mrsp.prod, 12);
		f10 = mulq_fin(mrsp.prod, 10);
		f17 = mulq_fin(mrsp.prod, 17);
		diff = (f32[63:0] >= s3_q) ? f32[63:0] - s3_q : s3_q - f32[63:0];
		lj_st = signed_term(f10[63:0], neg_q);
		lj_sum = sadd(lj_q, term_q);
		fd_st = signed_term(f12[63:0], d_cur[32] != it_q.q[15]);
		fd_sum = sadd(facc_q[axis_q], fd_st[63:0]);
		e2_sum = {1'b0, e2_q} + {1'b0, f32[63:0]};
		al_st = signed_term(f17[63:0], 1'b1);
		al_sum = sadd(lj_q, al_st[63:0]);
		sq_sh = {sq_rem_q[32:0], sq_v_q[63:62]};
		sq_trial = {1'b0, rr_q, 2'b01};
		sq_ge = sq_sh >= sq_trial;
		root_new = {rr_q[30:0], sq_ge};
		abs_q = it_q.q[15] ? 16'(-it_q.q) : it_q.q;
	end

	assign pop = (state_q == ST_IDLE) && head_valid;
	assign out_valid = out_valid_q;
	assign total_energy = out_total_q;
	assign overlap_or_saturated = out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			lj_q <= '0;
			facc_q[0] <= '0;
			facc_q[1] <= '0;
			facc_q[2] <= '0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mreq_q.start <= 1'b0;
			dreq_q.start <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						it_q <= head;
						sat_q <= 1'b0;
						ls_q <= 1'b0;
						axis_q <= 2'd0;
						r2q_q <= '0;
						if (head.coincident) begin
							err_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							mreq_q <= '{1'b1, 64'(abs_d(head.d_x)), 64'(abs_d(head.d_x))};
							state_q <= ST_SQ_WAIT;
						end
					end
				end
				ST_SQ_WAIT: begin
					if (mrsp.done) begin
						r2q_q <= r2q_new;
						if (axis_q == 2'd2) begin
							axis_q <= 2'd0;
							if (it_q.eps != 16'd0) begin
								dreq_q <= '{1'b1, 64'(32'(it_q.sig) * 32'(it_q.sig)), r2q_new, K_S};
								state_q <= ST_LJ_DIV;
							end else begin
								state_q <= ST_DIP;
							end
						end else begin
							axis_q <= axis_q + 2'd1;
							mreq_q <= '{1'b1, 64'(abs_d(d_next)), 64'(abs_d(d_next))};
						end
					end
				end
				ST_LJ_DIV: begin
					if (drsp.done) begin
						s_q <= drsp.quo;
						ls_q <= drsp.sat;
						mreq_q <= '{1'b1, drsp.quo, drsp.quo};
						state_q <= ST_LJ_M1;
					end
				end
				ST_LJ_M1: begin
					if (mrsp.done) begin
						ls_q <= ls_q | f32[64];
						mreq_q <= '{1'b1, f32[63:0], s_q};
						state_q <= ST_LJ_M2;
					end
				end
				ST_LJ_M2: begin
					if (mrsp.done) begin
						s3_q <= f32[63:0];
						ls_q <= ls_q | f32[64];
						mreq_q <= '{1'b1, f32[63:0], f32[63:0]};
						state_q <= ST_LJ_M3;
					end
				end
				ST_LJ_M3: begin
					if (mrsp.done) begin
						// Any saturation inside the LJ chain pins the term to its positive limit.
						if (ls_q || f32[64]) begin
							term_q <= INT64_MAX;
							sat_q <= 1'b1;
							state_q <= ST_LJ_ADD;
						end else begin
							neg_q <= f32[63:0] < s3_q;
							mreq_q <= '{1'b1, diff, 64'(it_q.eps)};
							state_q <= ST_LJ_M4;
						end
					end
				end
				ST_LJ_M4: begin
					if (mrsp.done) begin
						term_q <= lj_st[63:0];
						sat_q <= sat_q | f10[64] | lj_st[64];
						state_q <= ST_LJ_ADD;
					end
				end
				ST_LJ_ADD: begin
					lj_q <= lj_sum[63:0];
					sat_q <= sat_q | lj_sum[64];
					state_q <= ST_DIP;
				end
				ST_DIP: begin
					if (dipole_enable) begin
						dreq_q <= '{1'b1, 64'd1, r2q_q, K_INV};
						state_q <= ST_INV_WAIT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_INV_WAIT: begin
					if (drsp.done) begin
						inv2_q <= drsp.quo;
						sat_q <= sat_q | drsp.sat;
						sq_v_q <= r2q_q;
						sq_rem_q <= '0;
						rr_q <= '0;
						sq_cnt_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					// One root bit per cycle from the top pair of radicand bits.
					sq_rem_q <= sq_ge ? sq_sh - sq_trial : sq_sh;
					rr_q <= root_new;
					sq_v_q <= {sq_v_q[61:0], 2'b00};
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'd31) begin
						axis_q <= 2'd0;
						dreq_q <= '{1'b1, 64'(abs_d(it_q.d_x)), 64'(root_new), K_C};
						state_q <= ST_C_WAIT;
					end
				end
				ST_C_WAIT: begin
					if (drsp.done) begin
						sat_q <= sat_q | drsp.sat;
						mreq_q <= '{1'b1, drsp.quo, inv2_q};
						state_q <= ST_F_M1;
					end
				end
				ST_F_M1: begin
					if (mrsp.done) begin
						sat_q <= sat_q | f32[64];
						mreq_q <= '{1'b1, f32[63:0], 64'(abs_q)};
						state_q <= ST_F_M2;
					end
				end
				ST_F_M2: begin
					if (mrsp.done) begin
						facc_q[axis_q] <= fd_sum[63:0];
						sat_q <= sat_q | f12[64] | fd_st[64] | fd_sum[64];
						if (axis_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							axis_q <= axis_q + 2'd1;
							dreq_q <= '{1'b1, 64'(abs_d(d_next)), 64'(rr_q), K_C};
							state_q <= ST_C_WAIT;
						end
					end
				end
				ST_FIN: begin
					err_q <= err_q | sat_q;
					fs_q <= 1'b0;
					e2_q <= '0;
					axis_q <= 2'd0;
					if (!it_q.last) begin
						state_q <= ST_IDLE;
					end else if (dipole_enable) begin
						mreq_q <= '{1'b1, abs64(facc_q[0]), abs64(facc_q[0])};
						state_q <= ST_E2_WAIT;
					end else begin
						total_q <= lj_q;
						state_q <= ST_OUT;
					end
				end
				ST_E2_WAIT: begin
					if (mrsp.done) begin
						if (axis_q == 2'd2) begin
							mreq_q <= '{1'b1, e2_sum[64] ? '1 : e2_sum[63:0],
								64'(probe_polarizability)};
							state_q <= ST_ALPHA_WAIT;
						end else begin
							mreq_q <= '{1'b1, abs64(facc_q[axis_q + 2'd1]),
								abs64(facc_q[axis_q + 2'd1])};
							axis_q <= axis_q + 2'd1;
						end
						e2_q <= e2_sum[64] ? '1 : e2_sum[63:0];
						fs_q <= fs_q | f32[64] | e2_sum[64];
					end
				end
				ST_ALPHA_WAIT: begin
					if (mrsp.done) begin
						total_q <= al_sum[63:0];
						fs_q <= fs_q | f17[64] | al_st[64] | al_sum[64];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_total_q <= total_q;
						out_flag_q <= err_q | fs_q;
						lj_q <= '0;
						facc_q[0] <= '0;
						facc_q[1] <= '0;
						facc_q[2] <= '0;
						err_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the Lennard-Jones energy sum with induced dipole term.
// Depends on lje_pkg and lj_induced_dipole_energy_sum; predicts each energy word in-bench.
module tb;
	import lje_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, pz, ax, ay, az;
		logic [15:0] eps, sig;
		logic signed [15:0] q;
		logic last;
	} atom_word_t;

	typedef struct {
		logic signed [63:0] energy;
		logic flag;
	} energy_word_t;

	localparam int FRAC = COORD_FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] probe_x = '0, probe_y = '0, probe_z = '0;
	logic signed [31:0] atom_x = '0, atom_y = '0, atom_z = '0;
	logic [15:0] atom_well_depth = '0, atom_radius = '0;
	logic signed [15:0] atom_charge = '0;
	logic last_atom = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] total_energy;
	logic overlap_or_saturated;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	lj_induced_dipole_energy_sum dut (.*);

	always #4 clk = ~clk;

	// Predictor copy of the block state and registers.
	logic dip_en;
	logic [31:0] alpha;
	logic signed [63:0] lj_sum, fx_sum, fy_sum, fz_sum;
	logic err_flag;

	energy_word_t energy_queue[$];
	int fail_count = 0;
	int idle_sender = 0, idle_receiver = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	function automatic logic [63:0] umag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : v;
	endfunction

	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
			input int sh, inout logic sat);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		if (|p[127:64]) begin
			sat = 1'b1;
			return '1;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] div_shift(input logic [63:0] a, input logic [63:0] b,
			input int k, inout logic sat);
		logic [191:0] n, qt;
		if (a == 0) return '0;
		if (b == 0) begin
			sat = 1'b1;
			return '1;
		end
		n = {128'd0, a} << k;
		qt = n / {128'd0, b};
		if (|qt[191:64]) begin
			sat = 1'b1;
			return '1;
		end
		return qt[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			logic [63:0] t;
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= {64'd0, v}) r = t;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] to_signed(input logic [63:0] m, input logic neg,
			inout logic sat);
		if (m[63]) begin
			sat = 1'b1;
			m = INT64_MAX;
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b, inout logic sat);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
			sat = 1'b1;
			return INT64_MAX;
		end
		if (s < -65'sh0_8000_0000_0000_0000) begin
			sat = 1'b1;
			return INT64_MIN;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] axis_field(input logic signed [63:0] d,
			input logic [63:0] inv2, input logic [63:0] rr, input logic signed [15:0] q,
			inout logic sat);
		logic [63:0] c, m;
		c = div_shift(umag(d), rr, 31, sat);
		m = mul_shift(mul_shift(c, inv2, 32, sat), umag(64'(q)), 12, sat);
		return to_signed(m, d[63] != q[15], sat);
	endfunction

	// Unsigned add that pins to all ones on overflow.
	function automatic logic [63:0] add_pin(input logic [63:0] a, input logic [63:0] b,
			inout logic sat);
		if (a > ~b) begin
			sat = 1'b1;
			return '1;
		end
		return a + b;
	endfunction

	// Advances the predicted accumulators by one atom; returns 1 with a word on the last.
	function automatic bit accumulate_atom(input atom_word_t w, output energy_word_t res);
		logic signed [63:0] dx, dy, dz, term, total;
		logic [63:0] r2q, s, s3, s6, inv2, rr, e2, t;
		logic sat, ls, fs;
		sat = 0; ls = 0; fs = 0;
		dx = 64'(w.px) - 64'(w.ax);
		dy = 64'(w.py) - 64'(w.ay);
		dz = 64'(w.pz) - 64'(w.az);
		res = '{0, 0};
		if (dx == 0 && dy == 0 && dz == 0) begin
			err_flag = 1'b1;
		end else begin
			r2q = ((umag(dx) * umag(dx)) >> 2) + ((umag(dy) * umag(dy)) >> 2)
				+ ((umag(dz) * umag(dz)) >> 2);
			if (w.eps != 0) begin
				s = div_shift(64'(w.sig) * 64'(w.sig), r2q, 2 * FRAC + 6, ls);
				s3 = mul_shift(mul_shift(s, s, 32, ls), s, 32, ls);
				s6 = mul_shift(s3, s3, 32, ls);
				if (ls) begin
					term = INT64_MAX;
					sat = 1'b1;
				end else if (s6 >= s3)
					term = to_signed(mul_shift(s6 - s3, 64'(w.eps), 10, sat), 1'b0, sat);
				else
					term = to_signed(mul_shift(s3 - s6, 64'(w.eps), 10, sat), 1'b1, sat);
				lj_sum = add_sat(lj_sum, term, sat);
			end
			if (dip_en) begin
				inv2 = div_shift(64'd1, r2q, 2 * FRAC + 30, sat);
				rr = int_sqrt(r2q);
				fx_sum = add_sat(fx_sum, axis_field(dx, inv2, rr, w.q, sat), sat);
				fy_sum = add_sat(fy_sum, axis_field(dy, inv2, rr, w.q, sat), sat);
				fz_sum = add_sat(fz_sum, axis_field(dz, inv2, rr, w.q, sat), sat);
			end
		end
		if (sat) err_flag = 1'b1;
		if (!w.last) return 0;
		total = lj_sum;
		if (dip_en) begin
			e2 = 0;
			t = mul_shift(umag(fx_sum), umag(fx_sum), 32, fs);
			e2 = add_pin(e2, t, fs);
			t = mul_shift(umag(fy_sum), umag(fy_sum), 32, fs);
			e2 = add_pin(e2, t, fs);
			t = mul_shift(umag(fz_sum), umag(fz_sum), 32, fs);
			e2 = add_pin(e2, t, fs);
			total = add_sat(total, to_signed(mul_shift(e2, 64'(alpha), 17, fs), 1'b1, fs), fs);
		end
		res.energy = total;
		res.flag = err_flag | fs;
		lj_sum = 0; fx_sum = 0; fy_sum = 0; fz_sum = 0; err_flag = 0;
		return 1;
	endfunction

	// Receiver with random stall and an optional long hold-off.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= idle_receiver);
	end

	// Checks each energy word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (energy_queue.size() == 0) begin
				$display("%0t: unexpected energy word %h flag %b", $time, total_energy,
					overlap_or_saturated);
				fail_count++;
			end else begin
				energy_word_t e;
				e = energy_queue.pop_front();
				if (total_energy !== e.energy) begin
					$display("%0t: total_energy expected %h actual %h", $time, e.energy,
						total_energy);
					fail_count++;
				end
				if (overlap_or_saturated !== e.flag) begin
					$display("%0t: overlap_or_saturated expected %b actual %b", $time, e.flag,
						overlap_or_saturated);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Valid drops only when the sender idles or the stream ends, so back-to-back words
	// keep it high.
	task automatic send_atom(input atom_word_t w);
		energy_word_t r;
		if ($urandom_range(99) < idle_sender) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_sender) @(posedge clk);
		end
		probe_x <= w.px; probe_y <= w.py; probe_z <= w.pz;
		atom_x <= w.ax; atom_y <= w.ay; atom_z <= w.az;
		atom_well_depth <= w.eps; atom_radius <= w.sig;
		atom_charge <= w.q; last_atom <= w.last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (accumulate_atom(w, r)) energy_queue.insert(energy_queue.size(), r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (energy_queue.size() != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIPOLE_ENABLE) dip_en = val[0];
		else alpha = val;
		@(posedge clk);
	endtask

	// Mostly near-field molecules so the energy terms stay in range, with some wild words.
	function automatic atom_word_t random_atom(input bit last);
		atom_word_t w;
		int unsigned pick;
		pick = $urandom_range(9);
		w.px = $urandom; w.py = $urandom; w.pz = $urandom;
		if (pick < 7) begin
			w.px = $signed(w.px) >>> $urandom_range(24, 8);
			w.py = $signed(w.py) >>> $urandom_range(24, 8);
			w.pz = $signed(w.pz) >>> $urandom_range(24, 8);
			w.ax = w.px + ($signed(32'($urandom)) >>> $urandom_range(26, 12));
			w.ay = w.py + ($signed(32'($urandom)) >>> $urandom_range(26, 12));
			w.az = w.pz + ($signed(32'($urandom)) >>> $urandom_range(26, 12));
		end else if (pick == 7) begin
			w.ax = w.px; w.ay = w.py; w.az = w.pz;
		end else begin
			w.ax = $urandom; w.ay = $urandom; w.az = $urandom;
		end
		w.eps = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
		w.sig = 16'($urandom);
		w.q = 16'($urandom);
		w.last = last;
		return w;
	endfunction

	task automatic random_phase(input int n, input int s_idle, input int r_idle);
		int left;
		idle_sender = s_idle;
		idle_receiver = r_idle;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) left = $urandom_range(6, 1);
			left--;
			send_atom(random_atom(left == 0 || i == n - 1));
		end
	endtask

	atom_word_t directed_table[$];
	energy_word_t directed_expect[$];
	bit directed_known[$];

	task automatic add_row(input atom_word_t w, input energy_word_t e, input bit known);
		directed_table.insert(directed_table.size(), w);
		directed_expect.insert(directed_expect.size(), e);
		directed_known.insert(directed_known.size(), known);
	endtask

	initial begin
		atom_word_t w;
		energy_word_t res;
		dip_en = 0; alpha = 0; lj_sum = 0; fx_sum = 0; fy_sum = 0; fz_sum = 0; err_flag = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: coincident atom (flagged, zero energy), zero well depth,
		// coordinate extremes, sub-LSB distance and plain near-field pairs.
		w = '{0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b1};
		add_row(w, energy_word_t'{0, 1'b1}, 1);
		w = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 16'h0, 16'hFFFF, 16'sh8000, 1'b1};
		add_row(w, energy_word_t'{0, 1'b0}, 1);
		w = '{32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b1};
		add_row(w, energy_word_t'{0, 0}, 0);
		w = '{1, 0, 0, 0, 0, 0, 16'h1000, 16'h1000, 16'sh1000, 1'b1};
		add_row(w, energy_word_t'{0, 0}, 0);
		w = '{32'h0004_0000, 0, 0, 0, 0, 0, 16'h1000, 16'h3000, 16'sh1000, 1'b0};
		add_row(w, energy_word_t'{0, 0}, 0);
		w = '{0, 32'h0003_0000, 0, 0, 0, 0, 16'h0800, 16'h3800, -16'sh0800, 1'b1};
		add_row(w, energy_word_t'{0, 0}, 0);

		idle_sender = 0; idle_receiver = 0;
		for (int pass = 0; pass < 2; pass++) begin
			foreach (directed_table[i]) begin
				send_atom(directed_table[i]);
				if (directed_known[i] && pass == 0 && energy_queue.size() != 0) begin
					res = energy_queue[$];
					if (res.energy !== directed_expect[i].energy
							|| res.flag !== directed_expect[i].flag) begin
						$display("%0t: row %0d predicted %h/%b, table %h/%b", $time, i,
							res.energy, res.flag, directed_expect[i].energy,
							directed_expect[i].flag);
						fail_count++;
					end
				end
			end
			drain();
			write_reg(REG_DIPOLE_ENABLE, 32'd1);
			write_reg(REG_POLARIZABILITY, 32'hFFFF_FFFF);
		end

		// Enable dropped mid-molecule.
		send_atom('{32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0, 16'h1000, 16'h2000, 16'sh2000, 0});
		drain();
		write_reg(REG_DIPOLE_ENABLE, 32'd0);
		send_atom('{0, 32'h0002_0000, 32'h0001_0000, 0, 0, 0, 16'h1000, 16'h2000, 16'sh2000, 1});
		drain();

		// Long receiver hold-off while atoms keep coming, long enough for two molecules
		// to finish so that the queue fills and the input stalls.
		write_reg(REG_DIPOLE_ENABLE, 32'd1);
		write_reg(REG_POLARIZABILITY, 32'h0001_8000);
		hold_off = 20000;
		random_phase(30, 0, 0);
		drain();

		write_reg(REG_POLARIZABILITY, 32'h0000_0000);
		random_phase(400, 22, 72);
		drain();
		write_reg(REG_DIPOLE_ENABLE, 32'd0);
		write_reg(REG_POLARIZABILITY, $urandom);
		random_phase(600, 72, 22);
		drain();
		write_reg(REG_DIPOLE_ENABLE, 32'd1);
		write_reg(REG_POLARIZABILITY, $urandom);
		random_phase(600, 0, 0);
		drain();

		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
